@@ rtl/cffpq_pkg.sv @@
// Package for the circular find-first-set priority queue.
// Holds widths, status codes and the command word shared by controller and datapath.
// No dependencies.
package cffpq_pkg;

	localparam int BUCKETS_DEF    = 64;
	localparam int FIFO_LOG2_DEF  = 4;
	localparam int PRIO_W         = 32;
	localparam int PKT_W          = 64;
	localparam int IDX_W          = 6;
	localparam int STATUS_W       = 2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic clear;   // zero one pointer entry after reset
		logic load;    // capture input word, read bucket pointers
		logic rd;      // read head packet of the target bucket
		logic exec;    // perform update, register result
	} dp_cmd_t;

endpackage

@@ rtl/cffpq_datapath.sv @@
// Datapath: bitmaps, per-bucket pointers, packet memory, window state.
// Depends on cffpq_pkg.
module cffpq_datapath #(
	parameter int BUCKETS   = cffpq_pkg::BUCKETS_DEF,
	parameter int FIFO_LOG2 = cffpq_pkg::FIFO_LOG2_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cffpq_pkg::dp_cmd_t                  cmd,
	input  logic                                in_cmd,
	input  logic [cffpq_pkg::PRIO_W-1:0]        in_prio,
	input  logic [cffpq_pkg::PKT_W-1:0]         in_pkt,
	output logic                                clr_last,
	output logic [cffpq_pkg::STATUS_W-1:0]      res_status,
	output logic [cffpq_pkg::PKT_W-1:0]         res_pkt,
	output logic [cffpq_pkg::IDX_W-1:0]         res_idx
);
	localparam int BW     = $clog2(BUCKETS);
	localparam int FW     = BW + 1;
	localparam int NF     = 1 << FW;
	localparam int DEPTH  = 1 << FIFO_LOG2;
	localparam int AW     = FW + FIFO_LOG2;
	localparam int CW     = FIFO_LOG2 + 1;
	localparam int PW     = FIFO_LOG2 + CW;

	logic               prim_q;
	logic [31:0]        base_q;
	logic [BUCKETS-1:0] map_q [2];
	logic [PW-1:0]      ptr_mem [NF];   // {head, count} per bucket
	logic [cffpq_pkg::PKT_W-1:0] store [NF*DEPTH];
	logic [FW-1:0]      clr_q;

	logic               cmd_q;
	logic [cffpq_pkg::PKT_W-1:0] pkt_q;
	logic [FW-1:0]      f_q;
	logic [BW-1:0]      loc_q;
	logic               swap_pre_q, empty_q;
	logic [FIFO_LOG2-1:0] head_q;
	logic [CW-1:0]        cnt_q;
	logic [cffpq_pkg::PKT_W-1:0] rd_q;

	// stage one: resolve target bucket
	logic [32:0] p33, b33, rel33;
	logic [FW-1:0] rel;
	logic          w_enq, w_deq, pempty, sempty;
	logic [BW-1:0] loc_enq, loc_deq;
	logic [FW-1:0] f_s;
	logic [BUCKETS-1:0] pmap;

	always_comb begin
		p33 = {1'b0, in_prio};
		b33 = {1'b0, base_q};
		rel33 = p33 - b33;
		if (p33 >= b33 + 33'(2*BUCKETS))
			rel = FW'(2*BUCKETS-1);
		else if (p33 < b33)
			rel = '0;
		else
			rel = rel33[FW-1:0];
		if (rel < FW'(BUCKETS)) begin
			w_enq = prim_q;
			loc_enq = rel[BW-1:0];
		end else begin
			w_enq = ~prim_q;
			loc_enq = BW'(rel - FW'(BUCKETS));
		end
		pempty = (map_q[prim_q] == '0);
		sempty = (map_q[~prim_q] == '0);
		w_deq = pempty ? ~prim_q : prim_q;
		pmap = map_q[w_deq];
		loc_deq = '0;
		for (int i = BUCKETS-1; i >= 0; i--)
			if (pmap[i]) loc_deq = BW'(i);
		if (in_cmd == cffpq_pkg::CMD_ENQ)
			f_s = {w_enq, loc_enq};
		else
			f_s = {w_deq, loc_deq};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= cffpq_pkg::CMD_ENQ;
			swap_pre_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.load) begin
			cmd_q <= in_cmd;
			swap_pre_q <= pempty && !sempty;
			empty_q <= pempty && sempty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pkt_q  <= in_pkt;
			f_q    <= f_s;
			loc_q  <= f_s[BW-1:0];
			{head_q, cnt_q} <= ptr_mem[f_s];
		end
		if (cmd.rd)
			rd_q <= store[{f_q, head_q}];
	end

	// pointer clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear)
			clr_q <= clr_q + FW'(1);
	end
	assign clr_last = (clr_q == '1);

	// stage two: update
	logic [BUCKETS-1:0] onehot;
	logic [FIFO_LOG2-1:0] slot;
	logic full;
	logic [BUCKETS-1:0] nmap;
	logic ptr_wr;
	logic [PW-1:0] ptr_nxt;
	assign onehot = BUCKETS'(1) << loc_q;
	assign slot = head_q + cnt_q[FIFO_LOG2-1:0];
	assign full = cnt_q[CW-1];
	assign nmap = map_q[f_q[FW-1]] & ~onehot;

	always_comb begin
		ptr_wr = 1'b0;
		ptr_nxt = {head_q, cnt_q};
		if (cmd_q == cffpq_pkg::CMD_ENQ) begin
			if (!full) begin
				ptr_wr = 1'b1;
				ptr_nxt = {head_q, cnt_q + CW'(1)};
			end
		end else if (!empty_q && cnt_q != '0) begin
			ptr_wr = 1'b1;
			ptr_nxt = {head_q + FIFO_LOG2'(1), cnt_q - CW'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear)
			ptr_mem[clr_q] <= '0;
		else if (cmd.exec && ptr_wr)
			ptr_mem[f_q] <= ptr_nxt;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && cmd_q == cffpq_pkg::CMD_ENQ && !full)
			store[AW'({f_q, slot})] <= pkt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_q <= 1'b0;
			base_q <= '0;
			map_q[0] <= '0;
			map_q[1] <= '0;
			res_status <= cffpq_pkg::ST_OK;
			res_pkt <= '0;
			res_idx <= '0;
		end else if (cmd.exec) begin
			res_idx <= cffpq_pkg::IDX_W'(loc_q);
			res_pkt <= '0;
			res_status <= cffpq_pkg::ST_OK;
			if (cmd_q == cffpq_pkg::CMD_ENQ) begin
				if (full)
					res_status <= cffpq_pkg::ST_FULL;
				else
					map_q[f_q[FW-1]] <= map_q[f_q[FW-1]] | onehot;
			end else if (empty_q) begin
				res_status <= cffpq_pkg::ST_EMPTY;
				res_idx <= '0;
			end else begin
				logic prim_n;
				prim_n = prim_q ^ swap_pre_q;
				if (cnt_q != '0)
					res_pkt <= rd_q;
				if (cnt_q <= CW'(1)) map_q[f_q[FW-1]] <= nmap;
				if ((cnt_q <= CW'(1) ? nmap == '0 : map_q[prim_n] == '0)
						&& map_q[~prim_n] != '0) begin
					prim_q <= ~prim_n;
					base_q <= base_q + 32'(BUCKETS) + (swap_pre_q ? 32'(BUCKETS) : 32'd0);
				end else begin
					prim_q <= prim_n;
					base_q <= base_q + (swap_pre_q ? 32'(BUCKETS) : 32'd0);
				end
			end
		end
	end
endmodule

@@ rtl/cffpq_ctrl.sv @@
// Controller: sequences pointer clear, then load, read, execute and output hold for one word.
// Depends on cffpq_pkg.
module cffpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               clr_last,
	output cffpq_pkg::dp_cmd_t cmd
);
	typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_EXEC, S_OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.clear = (state_q == S_CLR);
	assign cmd.load = in_valid && in_ready;
	assign cmd.rd = (state_q == S_READ);
	assign cmd.exec = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			unique case (state_q)
				S_CLR:  if (clr_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/circular_ffs_priority_queue_top.sv @@
// Top level of the circular find-first-set priority queue.
// Depends on cffpq_pkg, cffpq_ctrl, cffpq_datapath.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: priority_req[31:0], packet_data[95:32]; tuser: cmd
// m_axis  | out | tdata: packet_out[63:0], bucket_index[69:64]; tuser: status
//
// Each word passes load, read, execute and output: load reads the bucket pointers,
// read fetches the head packet, execute updates bitmap/pointers, then the result is held.
// arst_n clears windows, base and bitmaps; a clearing pass then zeroes all
// 2^(clog2(BUCKETS)+1) pointer entries (128 at the defaults) with s_axis ready held low.
// Packet memory is not cleared.
// A stalled m_axis holds the result and s_axis ready stays low until it is taken.
module circular_ffs_priority_queue_top #(
	parameter int BUCKETS   = cffpq_pkg::BUCKETS_DEF,
	parameter int FIFO_LOG2 = cffpq_pkg::FIFO_LOG2_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // priority_req, packet_data
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // packet_out, bucket_index, zero pad
	output logic [1:0]  m_axis_tuser    // status
);
	cffpq_pkg::dp_cmd_t cmd;
	logic        clr_last;
	logic [63:0] pkt;
	logic [5:0]  idx;

	cffpq_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.clr_last,
		.cmd
	);

	cffpq_datapath #(.BUCKETS(BUCKETS), .FIFO_LOG2(FIFO_LOG2)) u_dp (
		.clk, .arst_n, .cmd,
		.in_cmd(s_axis_tuser),
		.in_prio(s_axis_tdata[31:0]),
		.in_pkt(s_axis_tdata[95:32]),
		.clr_last,
		.res_status(m_axis_tuser),
		.res_pkt(pkt),
		.res_idx(idx)
	);

	assign m_axis_tdata = {2'b00, idx, pkt};

	// hold result while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	// no input taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("input ready with pending result");
	// a full status never carries a packet
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != cffpq_pkg::ST_FULL || m_axis_tdata[63:0] == 64'd0)
		else $error("full status with packet");
endmodule
